// ===== hdl/bssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_pkg
// Shared types and constants of the bounded stack with shift and reverse.
// ----------------------------------------------------------------------------
package bssr_pkg;

    // The store depth is a power of two, so slot arithmetic wraps by itself.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int POS_W      = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_SHIFT   = 3'd2,
        OP_PEEK    = 3'd3,
        OP_READ    = 3'd4,
        OP_REVERSE = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  success;
        logic [CNT_W-1:0]      fill_count;
    } t_result;

endpackage

// ===== hdl/bssr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bssr_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 64,
    localparam int AW    = $clog2(WORDS)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bssr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssr_ctrl
// Request sequencer: keeps base slot, fill count and direction, addresses the
// item memory and assembles one result per request.
// ----------------------------------------------------------------------------
module bssr_ctrl import bssr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [DATA_WIDTH-1:0] i_item_value,
    input  logic [POS_W-1:0]      i_position,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_wr_en,
    output logic [ADDR_W-1:0]     o_wr_addr,
    output logic [DATA_WIDTH-1:0] o_wr_data,
    output logic                  o_rd_en,
    output logic [ADDR_W-1:0]     o_rd_addr,
    input  logic [DATA_WIDTH-1:0] i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DONE = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic                  r_rev, n_rev;
    logic                  r_use_mem, n_use_mem;
    logic                  r_ok, n_ok;
    logic [DATA_WIDTH-1:0] r_value, n_value;

    logic              accept;
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] top_slot;
    logic [ADDR_W-1:0] pos_slot;

    assign accept   = i_req_valid && o_req_ready;
    assign empty    = (r_fill == '0);
    assign full     = (r_fill == CNT_W'(DEPTH));
    assign top_slot = r_base + r_fill[ADDR_W-1:0] - ADDR_W'(1);
    assign pos_slot = r_rev ? (top_slot - ADDR_W'(i_position))
                            : (r_base + ADDR_W'(i_position));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_base    = r_base;
        n_rev     = r_rev;
        n_use_mem = r_use_mem;
        n_ok      = r_ok;
        n_value   = r_value;
        o_wr_en   = 1'b0;
        o_wr_addr = r_base + r_fill[ADDR_W-1:0];
        o_wr_data = i_item_value;
        o_rd_en   = 1'b0;
        o_rd_addr = top_slot;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_DONE;
                    n_use_mem = 1'b0;
                    n_ok      = 1'b0;
                    n_value   = '0;
                    case (t_opcode'(i_opcode))
                        OP_PUSH: begin
                            if (!full) begin
                                o_wr_en = 1'b1;
                                if (r_rev) begin
                                    n_base    = r_base - ADDR_W'(1);
                                    o_wr_addr = r_base - ADDR_W'(1);
                                end
                                n_fill  = r_fill + CNT_W'(1);
                                n_ok    = 1'b1;
                                n_value = i_item_value;
                            end
                        end
                        OP_POP: begin
                            if (!empty) begin
                                o_rd_en = 1'b1;
                                if (r_rev) begin
                                    o_rd_addr = r_base;
                                    n_base    = r_base + ADDR_W'(1);
                                end
                                n_fill    = r_fill - CNT_W'(1);
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_SHIFT: begin
                            if (!empty) begin
                                o_rd_en = 1'b1;
                                if (!r_rev) begin
                                    o_rd_addr = r_base;
                                    n_base    = r_base + ADDR_W'(1);
                                end
                                n_fill    = r_fill - CNT_W'(1);
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (!empty) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_rev ? r_base : top_slot;
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (CNT_W'(i_position) < r_fill) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = pos_slot;
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                            end
                        end
                        OP_REVERSE: begin
                            n_rev = !r_rev;
                            n_ok  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.value      = r_use_mem ? i_rd_data : r_value;
    assign o_res.success    = r_ok;
    assign o_res.fill_count = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_base  <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_base  <= n_base;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_use_mem <= n_use_mem;
        r_ok      <= n_ok;
        r_value   <= n_value;
    end

endmodule

// ===== hdl/bounded_stack_with_shift_and_reverse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_shift_and_reverse_top
// Bounded stack of item words with push, pop, shift, peek, indexed read and
// reverse, kept in a circular item memory.
//
//   Channel   Direction  tdata (low bit up)           tuser
//   s (req)   in         item_value, position         opcode
//   m (res)   out        result_value, fill_count     success
//
// A request is not accepted while the sequencer still holds the previous
// result. The memory access happens at acceptance, and the result, set by
// the registered read of the item memory, is held in the done state of the
// sequencer and then moves into the output register, from which it is
// offered on the master side. A new request is taken while the previous
// result waits in the output register. The reset is synchronous and active
// low and empties the stack. A stalled output holds one result and one
// request in flight, then the request side stalls.
// ----------------------------------------------------------------------------
module bounded_stack_with_shift_and_reverse_top import bssr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // item_value[31:0], position[37:32], zero pad
    input  logic [2:0]  i_s_tuser,   // opcode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // result_value[31:0], fill_count[38:32], zero pad
    output logic        o_m_tuser    // success
);

    logic                  res_valid;
    logic                  res_ready;
    t_result               res;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  r_out_valid;
    t_result               r_out;

    bssr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_opcode     (i_s_tuser),
        .i_item_value (i_s_tdata[31:0]),
        .i_position   (i_s_tdata[37:32]),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    bssr_ram #(
        .DATA_W (DATA_WIDTH),
        .WORDS  (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.fill_count, r_out.value};
    assign o_m_tuser  = r_out.success;

endmodule
